FILE: rtl/mrpt_pkg.sv
// Package with constants, types and tables for the Miller-Rabin primality tester.
package mrpt_pkg;
	localparam int unsigned WORD_BITS_DEF = 64;
	localparam int unsigned BASE_COUNT_DEF = 7;
	localparam int unsigned BASE_TABLE_LEN = 12;
	localparam int unsigned BASE_BITS = 6;
	localparam int unsigned BASE_IDX_BITS = 4;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_SHIFT_D,
		DP_LOAD_BASE,
		DP_MUL_RES,
		DP_MUL_SQ,
		DP_MUL_X
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [BASE_IDX_BITS-1:0] base_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic d_odd;
		logic e_zero;
		logic e_lsb;
		logic x_is_one;
		logic x_is_nm1;
		logic base_zero;
		logic n_small_prime;
		logic n_lt2;
		logic n_even;
		logic s_more;
	} dp_status_t;

	function automatic logic [BASE_BITS-1:0] witness(input logic [BASE_IDX_BITS-1:0] idx);
		case (idx)
			4'd0: witness = 6'd2;
			4'd1: witness = 6'd3;
			4'd2: witness = 6'd5;
			4'd3: witness = 6'd7;
			4'd4: witness = 6'd11;
			4'd5: witness = 6'd13;
			4'd6: witness = 6'd17;
			4'd7: witness = 6'd19;
			4'd8: witness = 6'd23;
			4'd9: witness = 6'd29;
			4'd10: witness = 6'd31;
			4'd11: witness = 6'd37;
			default: witness = 6'd2;
		endcase
	endfunction
endpackage

FILE: rtl/miller_rabin_primality_test.sv
// Top level of the deterministic Miller-Rabin primality tester.
// Channel | Signals                        | Direction
// input   | candidate, in_valid, in_ready  | into block
// output  | is_prime, out_valid, out_ready | out of block
// One candidate is processed at a time; in_ready is high only while idle.
// Each modular multiplication runs bit-serially in the shift-add reducer.
// Trivial cases (below 2, even, small primes) finish without running the test.
// The result holds on is_prime until out_ready; reset returns to idle.
module miller_rabin_primality_test #(
	parameter int unsigned WORD_BITS = mrpt_pkg::WORD_BITS_DEF,
	parameter int unsigned BASE_COUNT = mrpt_pkg::BASE_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [63:0] candidate,
	input  logic in_valid,
	output logic in_ready,
	output logic is_prime,
	output logic out_valid,
	input  logic out_ready
);
	import mrpt_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	mrpt_ctrl #(.BASE_COUNT(BASE_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_rdy(in_ready),
		.out_vld(out_valid), .out_rdy(out_ready), .verdict(is_prime),
		.cmd(cmd), .status(status)
	);

	mrpt_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .n_in(candidate[WORD_BITS-1:0]),
		.cmd(cmd), .status(status)
	);
endmodule

FILE: rtl/mrpt_datapath.sv
// Datapath holding n, d, the exponent and the modular shift-add multiplier.
module mrpt_datapath #(
	parameter int unsigned WORD_BITS = mrpt_pkg::WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [WORD_BITS-1:0] n_in,
	input  mrpt_pkg::dp_cmd_t cmd,
	output mrpt_pkg::dp_status_t status
);
	import mrpt_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

	typedef enum logic [1:0] {
		DST_RES,
		DST_SQ,
		DST_X
	} dst_t;

	logic [WORD_BITS-1:0] n_q, d_q, e_q, res_q, sq_q, x_q, acc_q, mx_q, my_q;
	logic [CNT_BITS-1:0] s_q, r_q, bit_q;
	logic busy_q;
	dst_t dst_q;
	logic [WORD_BITS-1:0] nm1, base_full, acc2, acc3, room1, room2;
	logic [WORD_BITS-1:0] base_mod;
	logic [BASE_BITS-1:0] base_small;
	logic n_wide;
	logic ge1, ge2;

	assign nm1 = n_q - WORD_BITS'(1);
	assign base_full = WORD_BITS'(witness(cmd.base_idx));
	assign n_wide = |n_q[WORD_BITS-1:BASE_BITS];
	// Table bases fit in six bits, so only a narrow n needs reducing; n is odd and at
	// least 9 here, so a table base (at most 37) needs at most four subtracts.
	always_comb begin
		base_small = witness(cmd.base_idx);
		if (!n_wide) begin
			for (int k = 0; k < 4; k++) begin
				if (base_small >= n_q[BASE_BITS-1:0])
					base_small = base_small - n_q[BASE_BITS-1:0];
			end
		end
	end
	assign base_mod = n_wide ? base_full : WORD_BITS'(base_small);

	assign room1 = n_q - acc_q;
	assign ge1 = acc_q >= room1;
	assign acc2 = ge1 ? acc_q - room1 : acc_q + acc_q;
	assign room2 = n_q - mx_q;
	assign ge2 = acc2 >= room2;
	assign acc3 = my_q[WORD_BITS-1] ? (ge2 ? acc2 - room2 : acc2 + mx_q) : acc2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
			d_q <= '0;
			e_q <= '0;
			res_q <= '0;
			sq_q <= '0;
			x_q <= '0;
			acc_q <= '0;
			mx_q <= '0;
			my_q <= '0;
			s_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			dst_q <= DST_RES;
		end else if (busy_q) begin
			acc_q <= acc3;
			my_q <= my_q << 1;
			bit_q <= bit_q - CNT_BITS'(1);
			if (bit_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				case (dst_q)
					DST_RES: res_q <= acc3;
					DST_SQ: sq_q <= acc3;
					default: x_q <= acc3;
				endcase
			end
		end else begin
			case (cmd.op)
				DP_LOAD: begin
					n_q <= n_in;
					d_q <= n_in - WORD_BITS'(1);
					s_q <= '0;
				end
				DP_SHIFT_D: begin
					d_q <= d_q >> 1;
					s_q <= s_q + CNT_BITS'(1);
				end
				DP_LOAD_BASE: begin
					sq_q <= base_mod;
					res_q <= WORD_BITS'(1);
					e_q <= d_q;
					r_q <= CNT_BITS'(1);
				end
				DP_MUL_RES: begin
					mx_q <= res_q; my_q <= sq_q; dst_q <= DST_RES;
					acc_q <= '0; bit_q <= CNT_BITS'(WORD_BITS); busy_q <= 1'b1;
				end
				DP_MUL_SQ: begin
					mx_q <= sq_q; my_q <= sq_q; dst_q <= DST_SQ;
					acc_q <= '0; bit_q <= CNT_BITS'(WORD_BITS); busy_q <= 1'b1;
					e_q <= e_q >> 1;
					x_q <= res_q;
				end
				DP_MUL_X: begin
					mx_q <= x_q; my_q <= x_q; dst_q <= DST_X;
					acc_q <= '0; bit_q <= CNT_BITS'(WORD_BITS); busy_q <= 1'b1;
					r_q <= r_q + CNT_BITS'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status.busy = busy_q;
		status.d_odd = d_q[0];
		status.e_zero = (e_q == '0);
		status.e_lsb = e_q[0];
		status.x_is_one = (x_q == WORD_BITS'(1));
		status.x_is_nm1 = (x_q == nm1);
		status.base_zero = (sq_q == '0);
		status.n_lt2 = (n_q < WORD_BITS'(2));
		status.n_even = ~n_q[0];
		status.s_more = (r_q < s_q);
		status.n_small_prime = (n_q == WORD_BITS'(2)) || (n_q == WORD_BITS'(3)) ||
			(n_q == WORD_BITS'(5)) || (n_q == WORD_BITS'(7)) ||
			(n_q == WORD_BITS'(11)) || (n_q == WORD_BITS'(13)) ||
			(n_q == WORD_BITS'(17)) || (n_q == WORD_BITS'(19)) ||
			(n_q == WORD_BITS'(23));
	end
endmodule

FILE: rtl/mrpt_ctrl.sv
// Controller state machine sequencing the test over bases and multiplications.
module mrpt_ctrl #(
	parameter int unsigned BASE_COUNT = mrpt_pkg::BASE_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	output logic in_rdy,
	output logic out_vld,
	input  logic out_rdy,
	output logic verdict,
	output mrpt_pkg::dp_cmd_t cmd,
	input  mrpt_pkg::dp_status_t status
);
	import mrpt_pkg::*;

	localparam int unsigned NB = (BASE_COUNT < BASE_TABLE_LEN) ? BASE_COUNT : BASE_TABLE_LEN;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SPLIT, S_BASE, S_BASE_CHK, S_POW, S_WAIT_RES,
		S_WAIT_SQ, S_POW_DONE, S_SQR, S_WAIT_X, S_NEXT, S_DONE
	} state_t;

	state_t state_q;
	logic [BASE_IDX_BITS-1:0] idx_q;
	logic verdict_q;

	assign in_rdy = (state_q == S_IDLE);
	assign out_vld = (state_q == S_DONE);
	assign verdict = verdict_q;

	always_comb begin
		cmd.base_idx = idx_q;
		cmd.op = DP_NOP;
		case (state_q)
			S_IDLE: cmd.op = in_fire ? DP_LOAD : DP_NOP;
			S_SPLIT: cmd.op = status.d_odd ? DP_NOP : DP_SHIFT_D;
			S_BASE: cmd.op = DP_LOAD_BASE;
			S_POW: cmd.op = status.e_zero ? DP_NOP : (status.e_lsb ? DP_MUL_RES : DP_MUL_SQ);
			S_WAIT_RES: cmd.op = status.busy ? DP_NOP : DP_MUL_SQ;
			S_SQR: cmd.op = (status.s_more && !status.x_is_nm1) ? DP_MUL_X : DP_NOP;
			default: cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			verdict_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_CHECK;
				S_CHECK: begin
					idx_q <= '0;
					if (status.n_lt2) begin
						verdict_q <= 1'b0; state_q <= S_DONE;
					end else if (status.n_small_prime) begin
						verdict_q <= 1'b1; state_q <= S_DONE;
					end else if (status.n_even) begin
						verdict_q <= 1'b0; state_q <= S_DONE;
					end else state_q <= S_SPLIT;
				end
				S_SPLIT: if (status.d_odd) state_q <= S_BASE;
				S_BASE: state_q <= S_BASE_CHK;
				S_BASE_CHK: state_q <= status.base_zero ? S_NEXT : S_POW;
				S_POW: begin
					if (status.e_zero) state_q <= S_POW_DONE;
					else if (status.e_lsb) state_q <= S_WAIT_RES;
					else state_q <= S_WAIT_SQ;
				end
				S_WAIT_RES: if (!status.busy) state_q <= S_WAIT_SQ;
				S_WAIT_SQ: if (!status.busy) state_q <= S_POW;
				S_POW_DONE: state_q <= (status.x_is_one || status.x_is_nm1) ? S_NEXT : S_SQR;
				S_SQR: begin
					if (status.x_is_nm1) state_q <= S_NEXT;
					else if (status.s_more) state_q <= S_WAIT_X;
					else begin
						verdict_q <= 1'b0; state_q <= S_DONE;
					end
				end
				S_WAIT_X: if (!status.busy) state_q <= S_SQR;
				S_NEXT: begin
					if (32'(idx_q) + 1 >= NB) begin
						verdict_q <= 1'b1; state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + BASE_IDX_BITS'(1); state_q <= S_BASE;
					end
				end
				S_DONE: if (out_rdy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: verif/mrpt_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each primality verdict and compares it with the block's output.
module mrpt_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic [63:0] candidate,
	input  logic in_valid,
	input  logic in_ready,
	input  logic is_prime,
	input  logic out_valid,
	input  logic out_ready,
	output int unsigned fail_count,
	output int unsigned verdicts_pending
);
	localparam int unsigned WITNESS_COUNT = 7;
	localparam logic [63:0] WITNESSES [WITNESS_COUNT] = '{64'd2, 64'd3, 64'd5, 64'd7,
		64'd11, 64'd13, 64'd17};
	localparam logic [63:0] SMALL_PRIMES [9] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11,
		64'd13, 64'd17, 64'd19, 64'd23};

	logic verdict_q [$];

	function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] prod;
		prod = {64'd0, x} * {64'd0, y};
		return 64'(prod % {64'd0, m});
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = b % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = mulmod(acc, sq, m);
			sq = mulmod(sq, sq, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic predict_prime(logic [63:0] n);
		logic [63:0] nm1;
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] a;
		int unsigned s;
		logic found;
		if (n < 64'd2)
			return 1'b0;
		foreach (SMALL_PRIMES[i])
			if (n == SMALL_PRIMES[i])
				return 1'b1;
		if (!n[0])
			return 1'b0;
		nm1 = n - 64'd1;
		d = nm1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		for (int i = 0; i < WITNESS_COUNT; i++) begin
			a = WITNESSES[i] % n;
			if (a == 64'd0)
				continue;
			x = powmod(a, d, n);
			if (x == 64'd1 || x == nm1)
				continue;
			found = 1'b0;
			for (int r = 1; r < s; r++) begin
				x = mulmod(x, x, n);
				if (x == nm1) begin
					found = 1'b1;
					break;
				end
			end
			if (!found)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	assign verdicts_pending = verdict_q.size();

	always @(posedge clk) begin
		logic want;
		if (arst_n) begin
			if (in_valid && in_ready)
				verdict_q.push_back(predict_prime(candidate));
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected transaction: is_prime=%0b", is_prime);
				end else begin
					want = verdict_q.pop_front();
					if (want !== is_prime) begin
						fail_count++;
						if (fail_count <= 10)
							$display("is_prime mismatch: expected %0b, got %0b", want, is_prime);
					end
				end
			end
		end
	end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the primality tester testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;
	logic clk;
	logic arst_n;
	logic [63:0] candidate;
	logic in_valid;
	logic in_ready;
	logic is_prime;
	logic out_valid;
	logic out_ready;
	int unsigned fail_count;
	int unsigned verdicts_pending;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic hold_off_req;
	longint unsigned cycle_count;

	localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

	miller_rabin_primality_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.candidate(candidate),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.is_prime(is_prime),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	mrpt_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.candidate(candidate),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.is_prime(is_prime),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fail_count(fail_count),
		.verdicts_pending(verdicts_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// The receiver stalls at random, and once holds off for a long stretch on request.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	task automatic send_candidate(input logic [63:0] n);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		candidate = n;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [63:0] random_candidate();
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 50)
			return 64'($urandom_range(65535, 0));
		else if (pick < 70)
			return {32'd0, $urandom()};
		else if (pick < 85)
			return {$urandom(), $urandom()};
		else
			return {40'd0, 24'($urandom()) | 24'd1};
	endfunction

	initial begin
		logic [63:0] directed [] = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd17,
			64'd23, 64'd25, 64'd29, 64'd561, 64'd2047, 64'd1373653, 64'd3215031751,
			64'd341550071728321, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFC5, 64'h1FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAB};
		arst_n = 1'b0;
		candidate = 64'd0;
		in_valid = 1'b0;
		hold_off_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_candidate(directed[i]);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 69 : 19) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 69 : 19) : 0;
			if (phase == 2)
				hold_off_req = 1'b1;
			for (int k = 0; k < 20; k++)
				send_candidate(random_candidate());
			if (phase == 1) begin
				while (verdicts_pending != 0)
					@(negedge clk);
			end
		end

		while (verdicts_pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
